// File: rtl/core/urc_pkg.sv
package urc_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [15:0] HDR_BYTES = 16'd8;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [15:0] CSUM_GOOD = 16'hFFFF;

    localparam logic [1:0] VERDICT_ACCEPT   = 2'd0;
    localparam logic [1:0] VERDICT_TRUNC    = 2'd1;
    localparam logic [1:0] VERDICT_LEN_ERR  = 2'd2;
    localparam logic [1:0] VERDICT_CSUM_ERR = 2'd3;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last;
        logic        first;
        logic        skip;
        logic        slot_en;
        logic [2:0]  idx;
        logic [15:0] pseudo;
        logic [15:0] count;
        logic        ovf;
    } t_entry;

    function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// File: rtl/core/udp_receive_checker.sv
// UDP receive checker for IPv4 segments.
// The input channel (i_valid, o_ready) carries one segment byte per beat, with
// i_last_byte on the final beat and the IPv4 source, destination and protocol
// taken from the beat that opens a segment. The output channel (o_valid,
// i_ready) carries one verdict beat per segment with the ports and payload length.
// The block takes one byte per cycle while o_ready is high. Once its last byte is
// accepted, a verdict passes through the queue between the classifier and the
// checksum unit, then through the result register, when nothing waits ahead of it.
// The checksum unit does one one's-complement add per 16-bit word of the segment.
// Reset clears the byte count, the queue, the running sum and o_valid.
// While a verdict waits for i_ready, bytes of the next segment keep flowing into
// the checksum unit; its final byte waits in the queue, and once the queue holds
// QUEUE_DEPTH beats o_ready falls until the waiting verdict is taken.
module udp_receive_checker #(
    parameter int unsigned QUEUE_DEPTH = urc_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [7:0]  i_proto_number,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_verdict,
    output logic [15:0] o_dest_port,
    output logic [15:0] o_source_port,
    output logic [15:0] o_payload_len
);
    import urc_pkg::*;

    logic   push_valid;
    logic   push_ready;
    t_entry push_data;
    logic   pop_valid;
    logic   pop_ready;
    t_entry pop_data;

    urc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_src_addr     (i_src_addr),
        .i_dst_addr     (i_dst_addr),
        .i_proto_number (i_proto_number),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_entry        (push_data)
    );

    urc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    urc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (pop_valid),
        .o_pop_ready   (pop_ready),
        .i_entry       (pop_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_verdict     (o_verdict),
        .o_dest_port   (o_dest_port),
        .o_source_port (o_source_port),
        .o_payload_len (o_payload_len)
    );

endmodule

// File: rtl/core/urc_front.sv
module urc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    input  logic [31:0]     i_src_addr,
    input  logic [31:0]     i_dst_addr,
    input  logic [7:0]      i_proto_number,
    output logic            o_push_valid,
    input  logic            i_push_ready,
    output urc_pkg::t_entry o_entry
);
    import urc_pkg::*;

    logic [15:0] r_cnt;
    logic        r_ovf;
    logic [15:0] n_cnt;
    logic        n_ovf;
    logic        ovf_hit;
    logic        skip;
    logic        accept;
    logic [18:0] ph_sum;
    logic [16:0] ph_fold;

    assign o_ready      = i_push_ready;
    assign o_push_valid = i_valid;
    assign accept       = i_valid && i_push_ready;

    assign ovf_hit = !r_ovf && (r_cnt == COUNT_MAX);
    assign skip    = r_ovf || ovf_hit;
    assign n_cnt   = skip ? r_cnt : r_cnt + 16'd1;
    assign n_ovf   = r_ovf || ovf_hit;

    // Pseudo-header sum: addresses, zero byte and protocol, folded twice.
    assign ph_sum  = 19'(i_src_addr[31:16]) + 19'(i_src_addr[15:0])
                   + 19'(i_dst_addr[31:16]) + 19'(i_dst_addr[15:0])
                   + 19'(i_proto_number);
    assign ph_fold = 17'(ph_sum[15:0]) + 17'(ph_sum[18:16]);

    always_comb begin
        o_entry.data_byte = i_data_byte;
        o_entry.last      = i_last_byte;
        o_entry.first     = !skip && (r_cnt == 16'd0);
        o_entry.skip      = skip;
        o_entry.slot_en   = !skip && (r_cnt < HDR_BYTES);
        o_entry.idx       = r_cnt[2:0];
        o_entry.pseudo    = ph_fold[15:0] + {15'd0, ph_fold[16]};
        o_entry.count     = n_cnt;
        o_entry.ovf       = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (accept) begin
            if (i_last_byte) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
            end
        end
    end

endmodule

// File: rtl/core/urc_queue.sv
module urc_queue #(
    parameter int unsigned DEPTH = urc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  urc_pkg::t_entry i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output urc_pkg::t_entry o_pop_data
);
    import urc_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/urc_back.sv
module urc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    input  urc_pkg::t_entry i_entry,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_verdict,
    output logic [15:0]     o_dest_port,
    output logic [15:0]     o_source_port,
    output logic [15:0]     o_payload_len
);
    import urc_pkg::*;

    logic [15:0] r_sum;
    logic [7:0]  r_hold;
    logic [15:0] r_len;
    logic [15:0] r_csum;
    logic [31:0] r_ports;
    logic        r_out_valid;
    logic [1:0]  r_verdict;
    logic [15:0] r_dport;
    logic [15:0] r_sport;
    logic [15:0] r_plen;

    logic [15:0] n_sum;
    logic [7:0]  n_hold;
    logic [15:0] n_len;
    logic [15:0] n_csum;
    logic [31:0] n_ports;
    logic [15:0] base;
    logic [15:0] word;
    logic        add_en;
    logic [15:0] fin;
    logic        trunc;
    logic        pop;
    logic [1:0]  verdict;

    assign o_pop_ready = !i_entry.last || !r_out_valid || i_ready;
    assign pop         = i_pop_valid && o_pop_ready;

    assign base   = i_entry.first ? i_entry.pseudo : r_sum;
    assign word   = i_entry.idx[0] ? {r_hold, i_entry.data_byte} : {i_entry.data_byte, 8'd0};
    assign add_en = !i_entry.skip && (i_entry.idx[0] || i_entry.last);
    assign n_sum  = add_en ? oc_add(base, word) : base;
    assign n_hold = (!i_entry.skip && !i_entry.idx[0]) ? i_entry.data_byte : r_hold;

    always_comb begin
        n_ports = r_ports;
        n_len   = r_len;
        n_csum  = r_csum;
        if (!i_entry.skip && i_entry.slot_en) begin
            case (i_entry.idx[2:1])
                2'd0: begin
                    if (i_entry.idx[0]) n_ports[23:16] = i_entry.data_byte;
                    else                n_ports[31:24] = i_entry.data_byte;
                end
                2'd1: begin
                    if (i_entry.idx[0]) n_ports[7:0]  = i_entry.data_byte;
                    else                n_ports[15:8] = i_entry.data_byte;
                end
                2'd2: begin
                    if (i_entry.idx[0]) n_len[7:0]  = i_entry.data_byte;
                    else                n_len[15:8] = i_entry.data_byte;
                end
                default: begin
                    if (i_entry.idx[0]) n_csum[7:0]  = i_entry.data_byte;
                    else                n_csum[15:8] = i_entry.data_byte;
                end
            endcase
        end
    end

    assign fin   = oc_add(n_sum, n_len);
    assign trunc = !i_entry.ovf && (i_entry.count < HDR_BYTES);

    always_comb begin
        if (trunc) begin
            verdict = VERDICT_TRUNC;
        end else if (i_entry.ovf || (i_entry.count != n_len)) begin
            verdict = VERDICT_LEN_ERR;
        end else if ((n_csum != 16'd0) && (fin != CSUM_GOOD)) begin
            verdict = VERDICT_CSUM_ERR;
        end else begin
            verdict = VERDICT_ACCEPT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_hold  <= '0;
            r_len   <= '0;
            r_csum  <= '0;
            r_ports <= '0;
        end else if (pop) begin
            if (i_entry.last) begin
                r_sum   <= '0;
                r_hold  <= '0;
                r_len   <= '0;
                r_csum  <= '0;
                r_ports <= '0;
            end else begin
                r_sum   <= n_sum;
                r_hold  <= n_hold;
                r_len   <= n_len;
                r_csum  <= n_csum;
                r_ports <= n_ports;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && i_entry.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_entry.last) begin
            r_verdict <= verdict;
            r_dport   <= trunc ? 16'd0 : n_ports[15:0];
            r_sport   <= trunc ? 16'd0 : n_ports[31:16];
            r_plen    <= trunc ? 16'd0 : i_entry.count - HDR_BYTES;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_verdict     = r_verdict;
    assign o_dest_port   = r_dport;
    assign o_source_port = r_sport;
    assign o_payload_len = r_plen;

endmodule

// File: rtl/core/urc_checker.sv
module urc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_verdict,
    input logic [15:0] o_dest_port,
    input logic [15:0] o_source_port,
    input logic [15:0] o_payload_len
);
    import urc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_verdict) && $stable(o_payload_len)
            && $stable(o_dest_port) && $stable(o_source_port))
        else $error("output beat changed while stalled");

    a_trunc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_verdict == VERDICT_TRUNC) |->
            (o_dest_port == 16'd0) && (o_source_port == 16'd0) && (o_payload_len == 16'd0))
        else $error("truncated segment reports nonzero fields");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_verdict != VERDICT_TRUNC) |-> (o_payload_len <= 16'd65527))
        else $error("payload length out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind udp_receive_checker urc_checker u_urc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_verdict     (o_verdict),
    .o_dest_port   (o_dest_port),
    .o_source_port (o_source_port),
    .o_payload_len (o_payload_len)
);

// File: bench/testbench.sv
module testbench;

    typedef struct {
        logic [1:0]  verdict;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [15:0] payload_len;
    } t_verdict;

    typedef enum {
        SEG_GOOD,
        SEG_ZERO_CSUM,
        SEG_BAD_CSUM,
        SEG_BAD_LEN,
        SEG_TRUNC,
        SEG_NOISE
    } t_seg_kind;

    typedef enum {
        RX_STREAM,
        RX_LIGHT_STALL,
        RX_HEAVY_STALL
    } t_rx_mode;

    function automatic bit [15:0] ones_add(bit [15:0] a, bit [15:0] b);
        bit [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    class verdict_tracker;
        bit [15:0] byte_cnt;
        bit        cnt_ovf;
        bit [15:0] sum;
        bit [7:0]  hold;
        bit [15:0] len_f;
        bit [15:0] csum_f;
        bit [31:0] ports;
        t_verdict  pending_verdicts[$];
        int        mismatches;

        function new();
            mismatches = 0;
            clear_segment();
        endfunction

        function void clear_segment();
            byte_cnt = 0;
            cnt_ovf = 0;
            sum = 0;
            hold = 0;
            len_f = 0;
            csum_f = 0;
            ports = 0;
        endfunction

        function void take_byte(bit [7:0] b, bit last, bit [31:0] src, bit [31:0] dst,
                                bit [7:0] proto);
            t_verdict e;
            if (!cnt_ovf && byte_cnt == 16'hFFFF) begin
                cnt_ovf = 1;
            end else if (!cnt_ovf) begin
                if (byte_cnt == 0) begin
                    sum = ones_add(sum, src[31:16]);
                    sum = ones_add(sum, src[15:0]);
                    sum = ones_add(sum, dst[31:16]);
                    sum = ones_add(sum, dst[15:0]);
                    sum = ones_add(sum, {8'h00, proto});
                end
                if (byte_cnt < 8) begin
                    case ({byte_cnt[2:1], byte_cnt[0]})
                        3'b000: ports[31:24] = b;
                        3'b001: ports[23:16] = b;
                        3'b010: ports[15:8] = b;
                        3'b011: ports[7:0] = b;
                        3'b100: len_f[15:8] = b;
                        3'b101: len_f[7:0] = b;
                        3'b110: csum_f[15:8] = b;
                        default: csum_f[7:0] = b;
                    endcase
                end
                if (!byte_cnt[0]) begin
                    if (last) begin
                        sum = ones_add(sum, {b, 8'h00});
                    end else begin
                        hold = b;
                    end
                end else begin
                    sum = ones_add(sum, {hold, b});
                end
                byte_cnt++;
            end
            if (!last) return;
            e.dest_port = 0;
            e.source_port = 0;
            e.payload_len = 0;
            if (!cnt_ovf && byte_cnt < 8) begin
                e.verdict = urc_pkg::VERDICT_TRUNC;
            end else begin
                e.dest_port = ports[15:0];
                e.source_port = ports[31:16];
                e.payload_len = byte_cnt - 16'd8;
                if (cnt_ovf || byte_cnt != len_f) begin
                    e.verdict = urc_pkg::VERDICT_LEN_ERR;
                end else if (csum_f != 0 && ones_add(sum, len_f) != 16'hFFFF) begin
                    e.verdict = urc_pkg::VERDICT_CSUM_ERR;
                end else begin
                    e.verdict = urc_pkg::VERDICT_ACCEPT;
                end
            end
            pending_verdicts.push_back(e);
            clear_segment();
        endfunction

        function void compare_verdict(logic [1:0] verdict, logic [15:0] dport,
                                      logic [15:0] sport, logic [15:0] plen);
            t_verdict e;
            if (pending_verdicts.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected verdict beat: verdict %0d dport %h sport %h len %0d",
                             verdict, dport, sport, plen);
                end
                mismatches++;
                return;
            end
            e = pending_verdicts.pop_front();
            if (verdict !== e.verdict || dport !== e.dest_port || sport !== e.source_port
                    || plen !== e.payload_len) begin
                if (mismatches < 10) begin
                    $display("verdict mismatch: expected %0d/%h/%h/%0d, got %0d/%h/%h/%0d",
                             e.verdict, e.dest_port, e.source_port, e.payload_len,
                             verdict, dport, sport, plen);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic [31:0] i_src_addr = 32'h0;
    logic [31:0] i_dst_addr = 32'h0;
    logic [7:0]  i_proto_number = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_verdict;
    logic [15:0] o_dest_port;
    logic [15:0] o_source_port;
    logic [15:0] o_payload_len;

    verdict_tracker tracker = new();
    int             bytes_sent = 0;
    int             burst_left = 0;

    udp_receive_checker DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_src_addr     (i_src_addr),
        .i_dst_addr     (i_dst_addr),
        .i_proto_number (i_proto_number),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_verdict      (o_verdict),
        .o_dest_port    (o_dest_port),
        .o_source_port  (o_source_port),
        .o_payload_len  (o_payload_len)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("[udp_receive_checker] ERROR");
        $finish;
    end

    task automatic send_byte(input bit [7:0] b, input bit last, input bit [31:0] src,
                             input bit [31:0] dst, input bit [7:0] proto);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        i_src_addr <= src;
        i_dst_addr <= dst;
        i_proto_number <= proto;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        tracker.take_byte(b, last, src, dst, proto);
        bytes_sent++;
    endtask

    task automatic send_segment(input t_seg_kind kind, input int unsigned n_bytes,
                                input bit [31:0] src, input bit [31:0] dst,
                                input bit [7:0] proto);
        bit [7:0]  seg[];
        bit [15:0] s;
        bit [15:0] c;
        bit [15:0] len_val;
        seg = new[n_bytes];
        foreach (seg[k]) seg[k] = 8'($urandom);
        if (kind != SEG_TRUNC && kind != SEG_NOISE) begin
            len_val = n_bytes[15:0];
            if (kind == SEG_BAD_LEN) len_val = len_val + 16'($urandom_range(1, 65535));
            seg[4] = len_val[15:8];
            seg[5] = len_val[7:0];
            if (kind == SEG_ZERO_CSUM) begin
                seg[6] = 8'h00;
                seg[7] = 8'h00;
            end else if (kind == SEG_GOOD || kind == SEG_BAD_CSUM) begin
                seg[6] = 8'h00;
                seg[7] = 8'h00;
                s = ones_add(src[31:16], src[15:0]);
                s = ones_add(s, dst[31:16]);
                s = ones_add(s, dst[15:0]);
                s = ones_add(s, {8'h00, proto});
                s = ones_add(s, len_val);
                for (int k = 0; k < n_bytes; k += 2) begin
                    s = ones_add(s, {seg[k], (k + 1 < n_bytes) ? seg[k + 1] : 8'h00});
                end
                if (kind == SEG_GOOD) begin
                    c = ~s;
                    if (c == 0) c = 16'hFFFF;
                end else begin
                    do c = 16'($urandom); while (c == 0 || ones_add(s, c) == 16'hFFFF);
                end
                seg[6] = c[15:8];
                seg[7] = c[7:0];
            end
        end
        foreach (seg[k]) begin
            if (k == 0) begin
                send_byte(seg[k], n_bytes == 1, src, dst, proto);
            end else begin
                send_byte(seg[k], k == n_bytes - 1, $urandom, $urandom, 8'($urandom));
            end
        end
    endtask

    initial begin : rx_pattern
        t_rx_mode mode;
        int       run_left;
        int       hold_left;
        int       verdicts_taken;
        bit       hold_done;
        mode = RX_STREAM;
        run_left = 0;
        hold_left = 0;
        verdicts_taken = 0;
        hold_done = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_ready) verdicts_taken++;
            if (!hold_done && verdicts_taken == 15) begin
                hold_left = 400;
                hold_done = 1;
            end
            if (run_left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 2));
                run_left = $urandom_range(10, 150);
            end
            run_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_STREAM: i_ready <= 1'b1;
                    RX_LIGHT_STALL: i_ready <= ($urandom_range(0, 3) != 0);
                    default: i_ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    initial begin : verdict_monitor
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && i_ready) begin
                tracker.compare_verdict(o_verdict, o_dest_port, o_source_port, o_payload_len);
            end
        end
    end

    initial begin : stimulus
        t_seg_kind kind;
        int        r;
        int        n;
        int        waited;
        int        failures;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_segment(SEG_TRUNC, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_segment(SEG_TRUNC, 3, 32'h0, 32'h0, 8'h00);
        send_segment(SEG_GOOD, 8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_segment(SEG_BAD_CSUM, 9, $urandom, $urandom, 8'd17);
        send_segment(SEG_ZERO_CSUM, 9, 32'h0, 32'h0, 8'h00);
        send_segment(SEG_BAD_LEN, 8, $urandom, $urandom, 8'd17);

        while (bytes_sent < 720) begin
            r = $urandom_range(0, 99);
            if (r < 55) kind = SEG_GOOD;
            else if (r < 65) kind = SEG_ZERO_CSUM;
            else if (r < 75) kind = SEG_BAD_CSUM;
            else if (r < 83) kind = SEG_BAD_LEN;
            else if (r < 90) kind = SEG_TRUNC;
            else kind = SEG_NOISE;
            if (kind == SEG_TRUNC) n = $urandom_range(1, 7);
            else if (kind == SEG_NOISE) n = $urandom_range(1, 30);
            else if ($urandom_range(0, 9) == 0) n = 8 + $urandom_range(0, 120);
            else n = 8 + $urandom_range(0, 24);
            send_segment(kind, n, $urandom, $urandom, 8'($urandom));
        end

        send_segment(SEG_GOOD, 12, $urandom, $urandom, 8'd17);

        i_valid <= 1'b0;
        waited = 0;
        while (tracker.pending_verdicts.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        failures = tracker.mismatches + tracker.pending_verdicts.size();
        if (failures == 0) begin
            $display("[udp_receive_checker] OK");
        end else begin
            $display("[udp_receive_checker] ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/urc_pkg.sv
rtl/core/urc_front.sv
rtl/core/urc_queue.sv
rtl/core/urc_back.sv
rtl/core/udp_receive_checker.sv
rtl/core/urc_checker.sv
bench/testbench.sv
